// ----- rtl/pfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  // Item kinds on the frame channel
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Fixed geometry
  localparam int KNOB_INPUTS = 4;
  localparam int BTN_COUNT   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Low byte of the second no-tag code (the other code is all zeros)
  localparam logic [7:0] NO_TAG_LOW = 8'hFF;

  // Register reset values
  localparam logic [7:0]  RST_JUMP_A    = 8'd10;
  localparam logic [7:0]  RST_JUMP_B    = 8'd20;
  localparam logic [7:0]  RST_SKIP_TOL  = 8'd2;
  localparam logic [15:0] RST_HOLD_MS   = 16'd500;
  localparam logic [7:0]  RST_ORANGE    = 8'd1;
  localparam logic [7:0]  RST_BAND      = 8'd2;
  localparam logic [7:0]  RST_SELECT    = 8'd4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JUMP_A      = 3'd0,
    REG_JUMP_B      = 3'd1,
    REG_SKIP_TOL    = 3'd2,
    REG_HOLD_MS     = 3'd3,
    REG_ORANGE_MASK = 3'd4,
    REG_BAND_MASK   = 3'd5,
    REG_SELECT_MASK = 3'd6
  } cfg_idx_t;

  // Register file contents
  typedef struct packed {
    logic [7:0]  jump_limit_a;
    logic [7:0]  jump_limit_b;
    logic [7:0]  skip_tolerance;
    logic [15:0] no_tag_hold_ms;
    logic [7:0]  orange_mask;
    logic [7:0]  band_mask;
    logic [7:0]  select_mask;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/pfc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Frame / tick request channel
interface pfc_in_if #(
  parameter int TAG_BYTES = 7
) ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [7:0]             button_bits;
  logic [7:0]             volume_raw;
  logic [7:0]             tone_raw;
  logic [7:0]             tuning_raw;
  logic [7:0]             bright_raw;
  logic [7:0]             fm_raw;
  logic [7:0]             control_code;
  logic [8*TAG_BYTES-1:0] tag_uid;
  logic                   warming_up;

  modport source (output valid, kind, button_bits, volume_raw, tone_raw, tuning_raw,
                  bright_raw, fm_raw, control_code, tag_uid, warming_up,
                  input ready);
  modport sink (input valid, kind, button_bits, volume_raw, tone_raw, tuning_raw,
                bright_raw, fm_raw, control_code, tag_uid, warming_up,
                output ready);
endinterface

// Conditioned frame result channel
interface pfc_out_if #(
  parameter int TAG_BYTES = 7
) ();
  logic                   valid;
  logic                   ready;
  logic [7:0]             volume_out;
  logic [7:0]             tone_out;
  logic [7:0]             tuning_out;
  logic [7:0]             bright_out;
  logic [7:0]             fm_out;
  logic [2:0]             button_toggles;
  logic [2:0]             button_levels;
  logic                   control_changed;
  logic [7:0]             control_out;
  logic                   tag_event;
  logic [8*TAG_BYTES-1:0] tag_out;

  modport source (output valid, volume_out, tone_out, tuning_out, bright_out, fm_out,
                  button_toggles, button_levels, control_changed, control_out,
                  tag_event, tag_out,
                  input ready);
  modport sink (input valid, volume_out, tone_out, tuning_out, bright_out, fm_out,
                button_toggles, button_levels, control_changed, control_out,
                tag_event, tag_out,
                output ready);
endinterface

// Register write channel
interface pfc_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [pfc_pkg::CFG_IDX_W-1:0]   index;
  logic [pfc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pfc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfc_cfg_regs
  import pfc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  pfc_cfg_if.sink    cfg,
  output cfg_t       regs
);

  cfg_idx_t idx;

  assign cfg.ready = 1'b1;
  assign idx       = cfg_idx_t'(cfg.index);

  // Register file, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.jump_limit_a   <= RST_JUMP_A;
      regs.jump_limit_b   <= RST_JUMP_B;
      regs.skip_tolerance <= RST_SKIP_TOL;
      regs.no_tag_hold_ms <= RST_HOLD_MS;
      regs.orange_mask    <= RST_ORANGE;
      regs.band_mask      <= RST_BAND;
      regs.select_mask    <= RST_SELECT;
    end else if (cfg.valid) begin
      case (idx)
        REG_JUMP_A:      regs.jump_limit_a   <= cfg.data[7:0];
        REG_JUMP_B:      regs.jump_limit_b   <= cfg.data[7:0];
        REG_SKIP_TOL:    regs.skip_tolerance <= cfg.data[7:0];
        REG_HOLD_MS:     regs.no_tag_hold_ms <= cfg.data;
        REG_ORANGE_MASK: regs.orange_mask    <= cfg.data[7:0];
        REG_BAND_MASK:   regs.band_mask      <= cfg.data[7:0];
        REG_SELECT_MASK: regs.select_mask    <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pfc_spike_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfc_spike_filter
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       we,
  input  wire logic [7:0] raw,
  input  wire logic       warm,
  input  wire logic [7:0] limit,
  input  wire logic [7:0] tol,
  output logic [7:0]      value_next
);

  logic [7:0] filtered;
  logic [7:0] held;
  logic       pending;
  logic [7:0] held_next;
  logic       pending_next;
  logic [7:0] jump;
  logic [7:0] skid_dist;

  // Distances to current value and to held spike
  assign jump      = (raw > filtered) ? raw - filtered : filtered - raw;
  assign skid_dist = (raw > held) ? raw - held : held - raw;

  // Spike hold decision
  always_comb begin
    value_next   = filtered;
    held_next    = held;
    pending_next = pending;
    if (warm) begin
      value_next = raw;
    end else if (raw != filtered) begin
      if (raw != 8'd0 && jump > limit) begin
        if (!pending) begin
          held_next    = raw;
          pending_next = 1'b1;
        end else if (skid_dist > tol) begin
          value_next   = raw;
          pending_next = 1'b0;
        end else begin
          held_next = raw;
        end
      end else begin
        value_next   = raw;
        pending_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered <= '0;
      held     <= '0;
      pending  <= 1'b0;
    end else if (we) begin
      filtered <= value_next;
      held     <= held_next;
      pending  <= pending_next;
    end
  end

  // A drop to zero outside warm-up always lands at once
  a_zero_drop: assert property (@(posedge clk) disable iff (rst)
    (we && !warm && raw == 8'd0) |=> (filtered == 8'd0))
    else $error("zero reading not taken");

endmodule

`default_nettype wire

// ----- rtl/pfc_tag_debounce.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfc_tag_debounce
  import pfc_pkg::*;
#(
  parameter int TAG_W = 56
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             frame_we,
  input  wire logic             tick_we,
  input  wire logic [TAG_W-1:0] uid,
  input  wire logic [15:0]      hold_ms,
  output logic                  tag_event,
  output logic [TAG_W-1:0]      tag_out
);

  logic [TAG_W-1:0] stored;
  logic             known;
  logic [15:0]      timer;
  logic             waiting;
  logic [TAG_W-1:0] stored_next;
  logic             known_next;
  logic [15:0]      timer_next;
  logic             waiting_next;
  logic             no_tag;

  assign no_tag = (uid == '0) || (uid == TAG_W'(NO_TAG_LOW));

  // Report / debounce decision for one frame
  always_comb begin
    stored_next  = stored;
    known_next   = known;
    timer_next   = timer;
    waiting_next = waiting;
    tag_event    = 1'b0;
    if (!known || uid != stored) begin
      if (no_tag) begin
        if (!waiting) begin
          timer_next   = '0;
          waiting_next = 1'b1;
        end else if (timer >= hold_ms) begin
          stored_next  = uid;
          known_next   = 1'b1;
          tag_event    = 1'b1;
          waiting_next = 1'b0;
        end
      end else begin
        stored_next  = uid;
        known_next   = 1'b1;
        tag_event    = 1'b1;
        waiting_next = 1'b0;
      end
    end else begin
      waiting_next = 1'b0;
    end
  end

  assign tag_out = known_next ? stored_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored  <= '0;
      known   <= 1'b0;
      timer   <= '0;
      waiting <= 1'b0;
    end else if (frame_we) begin
      stored  <= stored_next;
      known   <= known_next;
      timer   <= timer_next;
      waiting <= waiting_next;
    end else if (tick_we && timer != 16'hFFFF) begin
      timer <= timer + 16'd1;
    end
  end

  // A reported tag leaves the store marked known
  a_event_known: assert property (@(posedge clk) disable iff (rst)
    (frame_we && tag_event) |=> known)
    else $error("tag reported but not stored");

endmodule

`default_nettype wire

// ----- rtl/panel_frame_conditioner.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Carries
// --------  ---------  ----------------------------------------------------
// cfg       in         register writes (index, data), always ready
// frame     in         panel frame or millisecond tick request
// result    out        conditioned frame, one per frame request, none per tick
//
// One request is taken per cycle while ready; a frame's result goes to the
// output register, or the skid if stalled. Filter, button and tag state
// update in the accept cycle, so back-to-back frames see each other's effect.
// Reset (synchronous) clears all state and restores register defaults.
// A skid register holds one extra result; frame.ready drops only while it is
// full, i.e. after the sink has stalled with a result already waiting.

module panel_frame_conditioner
  import pfc_pkg::*;
#(
  parameter int ANALOG_CHANNELS = 4,
  parameter int TAG_BYTES       = 7
) (
  input  wire logic clk,
  input  wire logic rst,
  pfc_cfg_if.sink   cfg,
  pfc_in_if.sink    frame,
  pfc_out_if.source result
);

  localparam int TAG_W = 8 * TAG_BYTES;

  typedef struct packed {
    logic [7:0]       volume;
    logic [7:0]       tone;
    logic [7:0]       tuning;
    logic [7:0]       bright;
    logic [7:0]       fm;
    logic [2:0]       toggles;
    logic [2:0]       levels;
    logic             ctl_changed;
    logic [7:0]       control;
    logic             tag_event;
    logic [TAG_W-1:0] tag;
  } res_t;

  cfg_t       regs;
  logic       accept;
  logic       frame_we;
  logic       tick_we;
  logic [7:0] knob_raw [KNOB_INPUTS];
  logic [7:0] knob_val [KNOB_INPUTS];
  logic [7:0] last_buttons;
  logic [7:0] last_control;
  logic [BTN_COUNT-1:0] lv_now;
  logic [BTN_COUNT-1:0] lv_old;
  logic             tag_event;
  logic [TAG_W-1:0] tag_val;
  res_t res;
  res_t out_q;
  res_t skid_q;
  logic out_valid;
  logic skid_valid;
  logic take;

  pfc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Request decode
  assign frame.ready = !skid_valid;
  assign accept      = frame.valid && frame.ready;
  assign frame_we    = accept && (frame.kind == KIND_FRAME);
  assign tick_we     = accept && (frame.kind == KIND_TICK);

  assign knob_raw[0] = frame.volume_raw;
  assign knob_raw[1] = frame.tone_raw;
  assign knob_raw[2] = frame.tuning_raw;
  assign knob_raw[3] = frame.bright_raw;

  // Analog spike filters, one per present channel
  for (genvar c = 0; c < KNOB_INPUTS; c++) begin : g_knob
    if (c < ANALOG_CHANNELS) begin : g_on
      pfc_spike_filter u_filt (
        .clk        (clk),
        .rst        (rst),
        .we         (frame_we),
        .raw        (knob_raw[c]),
        .warm       (frame.warming_up),
        .limit      ((c < 2) ? regs.jump_limit_a : regs.jump_limit_b),
        .tol        (regs.skip_tolerance),
        .value_next (knob_val[c])
      );
    end else begin : g_off
      assign knob_val[c] = '0;
    end
  end

  pfc_tag_debounce #(
    .TAG_W (TAG_W)
  ) u_tag (
    .clk       (clk),
    .rst       (rst),
    .frame_we  (frame_we),
    .tick_we   (tick_we),
    .uid       (frame.tag_uid),
    .hold_ms   (regs.no_tag_hold_ms),
    .tag_event (tag_event),
    .tag_out   (tag_val)
  );

  // Button levels under current masks, old and new
  assign lv_now = {|(frame.button_bits & regs.select_mask),
                   |(frame.button_bits & regs.band_mask),
                   |(frame.button_bits & regs.orange_mask)};
  assign lv_old = {|(last_buttons & regs.select_mask),
                   |(last_buttons & regs.band_mask),
                   |(last_buttons & regs.orange_mask)};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_buttons <= '0;
      last_control <= '0;
    end else if (frame_we) begin
      last_buttons <= frame.button_bits;
      last_control <= frame.control_code;
    end
  end

  // Result assembly
  always_comb begin
    res.volume      = knob_val[0];
    res.tone        = knob_val[1];
    res.tuning      = knob_val[2];
    res.bright      = knob_val[3];
    res.fm          = frame.fm_raw;
    res.toggles     = lv_now ^ lv_old;
    res.levels      = lv_now;
    res.ctl_changed = frame.control_code != last_control;
    res.control     = frame.control_code;
    res.tag_event   = tag_event;
    res.tag         = tag_val;
  end

  // Output register plus skid
  assign take = out_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= frame_we;
      end
    end else if (frame_we) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (frame_we) begin
        out_q <= res;
      end
    end else if (frame_we) begin
      skid_q <= res;
    end
  end

  assign result.valid           = out_valid;
  assign result.volume_out      = out_q.volume;
  assign result.tone_out        = out_q.tone;
  assign result.tuning_out      = out_q.tuning;
  assign result.bright_out      = out_q.bright;
  assign result.fm_out          = out_q.fm;
  assign result.button_toggles  = out_q.toggles;
  assign result.button_levels   = out_q.levels;
  assign result.control_changed = out_q.ctl_changed;
  assign result.control_out     = out_q.control;
  assign result.tag_event       = out_q.tag_event;
  assign result.tag_out         = out_q.tag;

  // Skid is only ever filled behind a waiting result
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result with the output empty");

  // A tick into an empty output yields nothing
  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    (tick_we && !out_valid && !skid_valid) |=> !out_valid)
    else $error("tick produced a result");

endmodule

`default_nettype wire
